[rtl/psid_pkg.sv]
// psid_pkg: shared types, range limits and constant byte tables of the
// pow seed index decoder; no dependencies
`default_nettype none

package psid_pkg;

  localparam int unsigned NUM_BYTES = 10;
  localparam int unsigned IDX_W     = 32;

  localparam logic [IDX_W-1:0] LIM_A   = 32'd131071;
  localparam logic [IDX_W-1:0] LIM_B   = 32'd262143;
  localparam logic [IDX_W-1:0] LIM_C   = 32'd4456447;
  localparam logic [IDX_W-1:0] LIM_D   = 32'd12845055;
  localparam logic [IDX_W-1:0] LIM_E   = 32'd29622271;
  localparam logic [IDX_W-1:0] LIM_F   = 32'd46399487;
  localparam logic [IDX_W-1:0] LIM_G   = 32'd63176703;
  localparam logic [IDX_W-1:0] LIM_TOP = 32'd600047615;

  typedef enum logic [3:0] {
    FR_ZERO,
    FR_A,
    FR_B,
    FR_C,
    FR_D,
    FR_E,
    FR_F,
    FR_G,
    FR_H
  } frame_e;

  typedef enum logic [3:0] {
    TAB_LIT,
    TAB_PREP,
    TAB_ING,
    TAB_INF,
    TAB_ADJ,
    TAB_AMB,
    TAB_TIMED,
    TAB_NS,
    TAB_NPL,
    TAB_MASS,
    TAB_INGINF,
    TAB_TIME,
    TAB_INGADJ
  } tab_e;

  // literal byte, or table address in the low bits
  typedef struct packed {
    tab_e       tab;
    logic [7:0] val;
  } desc_t;

  localparam logic [7:0] PREP_TAB [8] = '{
    8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd12, 8'd13};

  localparam logic [7:0] ING_TAB [32] = '{
    8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33,
    8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41,
    8'd42, 8'd43, 8'd23, 8'd24, 8'd31, 8'd32, 8'd33, 8'd34};

  localparam logic [7:0] INF_TAB [16] = '{
    8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd50, 8'd51, 8'd52,
    8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60};

  localparam logic [7:0] ADJ_TAB [64] = '{
    8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,
    8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd76,
    8'd77,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,  8'd83,  8'd84,
    8'd85,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,  8'd91,  8'd92,
    8'd94,  8'd95,  8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101,
    8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109, 8'd110,
    8'd112, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
    8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128};

  localparam logic [7:0] AMB_TAB [16] = '{
    8'd77,  8'd94,  8'd95,  8'd96,  8'd126, 8'd214, 8'd217, 8'd218,
    8'd220, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd227, 8'd228};

  localparam logic [7:0] TIMED_TAB [8] = '{
    8'd84, 8'd243, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd255};

  localparam logic [7:0] NS_TAB [64] = '{
    8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
    8'd137, 8'd138, 8'd145, 8'd149, 8'd154, 8'd155, 8'd156, 8'd157,
    8'd177, 8'd178, 8'd179, 8'd180, 8'd182, 8'd183, 8'd184, 8'd185,
    8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd193,
    8'd194, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd202,
    8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd209, 8'd210,
    8'd211, 8'd212, 8'd213, 8'd241, 8'd244, 8'd245, 8'd246, 8'd247,
    8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255};

  localparam logic [7:0] NPL_TAB [32] = '{
    8'd139, 8'd140, 8'd141, 8'd142, 8'd143, 8'd144, 8'd146, 8'd147,
    8'd148, 8'd150, 8'd151, 8'd153, 8'd158, 8'd159, 8'd160, 8'd161,
    8'd162, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd168, 8'd169,
    8'd170, 8'd171, 8'd172, 8'd173, 8'd174, 8'd175, 8'd176, 8'd181};

  localparam logic [7:0] MASS_TAB [32] = '{
    8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221,
    8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229,
    8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237,
    8'd238, 8'd239, 8'd240, 8'd242, 8'd214, 8'd215, 8'd216, 8'd219};

  localparam logic [7:0] INGINF_TAB [32] = '{
    8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd25, 8'd26, 8'd27,
    8'd28, 8'd29, 8'd30, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
    8'd41, 8'd42, 8'd44, 8'd46, 8'd47, 8'd48, 8'd49, 8'd51,
    8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59};

  localparam logic [7:0] TIME_TAB [16] = '{
    8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd243,
    8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd253};

  localparam logic [7:0] INGADJ_TAB [64] = '{
    8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33,
    8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41,
    8'd42, 8'd43, 8'd23, 8'd24, 8'd31, 8'd32, 8'd33, 8'd34,
    8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68,
    8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76,
    8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
    8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd92};

  function automatic logic [7:0] tab_read(desc_t d);
    logic [7:0] r;
    r = '0;
    case (d.tab)
      TAB_LIT:    r = d.val;
      TAB_PREP:   r = PREP_TAB[d.val[2:0]];
      TAB_ING:    r = ING_TAB[d.val[4:0]];
      TAB_INF:    r = INF_TAB[d.val[3:0]];
      TAB_ADJ:    r = ADJ_TAB[d.val[5:0]];
      TAB_AMB:    r = AMB_TAB[d.val[3:0]];
      TAB_TIMED:  r = TIMED_TAB[d.val[2:0]];
      TAB_NS:     r = NS_TAB[d.val[5:0]];
      TAB_NPL:    r = NPL_TAB[d.val[4:0]];
      TAB_MASS:   r = MASS_TAB[d.val[4:0]];
      TAB_INGINF: r = INGINF_TAB[d.val[4:0]];
      TAB_TIME:   r = TIME_TAB[d.val[3:0]];
      TAB_INGADJ: r = INGADJ_TAB[d.val[5:0]];
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/psid_byte_map.sv]
// psid_byte_map: per-frame byte layout, gives a literal or a table address
// for each seed byte; depends on psid_pkg
`default_nettype none

module psid_byte_map (
  input  psid_pkg::frame_e      frame_i,
  input  logic [31:0]           index_i,
  output psid_pkg::desc_t       desc_o [psid_pkg::NUM_BYTES]
);
  import psid_pkg::*;

  function automatic desc_t lit(logic [7:0] v);
    desc_t d;
    d.tab = TAB_LIT;
    d.val = v;
    return d;
  endfunction

  function automatic desc_t tab(tab_e t, logic [5:0] a);
    desc_t d;
    d.tab = t;
    d.val = {2'b00, a};
    return d;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      desc_o[i] = lit(8'd0);
    end
    case (frame_i)
      FR_A: begin
        desc_o[0] = tab(TAB_PREP, {3'b000, index_i[2:0]});
        desc_o[1] = tab(TAB_TIMED, {3'b000, index_i[5:3]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = lit(8'd5);
        desc_o[4] = tab(TAB_NS, index_i[11:6]);
        desc_o[5] = lit(8'd1);
        desc_o[6] = tab(TAB_ING, {1'b0, index_i[16:12]});
      end
      FR_B: begin
        desc_o[0] = tab(TAB_TIME, {2'b00, index_i[3:0]});
        desc_o[1] = tab(TAB_MASS, {1'b0, index_i[8:4]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_INF, {2'b00, index_i[12:9]});
        desc_o[4] = lit(8'd9);
        desc_o[5] = lit(8'd2);
        desc_o[6] = lit(8'd1);
        desc_o[7] = tab(TAB_AMB, {2'b00, index_i[16:13]});
      end
      FR_C: begin
        desc_o[0] = tab(TAB_PREP, {3'b000, index_i[2:0]});
        desc_o[1] = tab(TAB_TIMED, {3'b000, index_i[5:3]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_ADJ, index_i[11:6]);
        desc_o[4] = tab(TAB_NPL, {1'b0, index_i[16:12]});
        desc_o[5] = lit(8'd1);
        desc_o[6] = tab(TAB_INGINF, {1'b0, index_i[21:17]});
      end
      FR_D: begin
        desc_o[0] = lit(8'd5);
        desc_o[1] = tab(TAB_NS, index_i[5:0]);
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_PREP, {3'b000, index_i[8:6]});
        desc_o[4] = tab(TAB_TIMED, {3'b000, index_i[11:9]});
        desc_o[5] = tab(TAB_MASS, {1'b0, index_i[16:12]});
        desc_o[6] = lit(8'd3);
        desc_o[7] = lit(8'd1);
        desc_o[8] = tab(TAB_ADJ, index_i[22:17]);
      end
      FR_E: begin
        desc_o[0] = tab(TAB_PREP, {3'b000, index_i[2:0]});
        desc_o[1] = tab(TAB_ADJ, index_i[8:3]);
        desc_o[2] = tab(TAB_MASS, {1'b0, index_i[13:9]});
        desc_o[3] = lit(8'd1);
        desc_o[4] = tab(TAB_NPL, {1'b0, index_i[18:14]});
        desc_o[5] = lit(8'd1);
        desc_o[6] = tab(TAB_INGINF, {1'b0, index_i[23:19]});
      end
      FR_F: begin
        desc_o[0] = tab(TAB_PREP, {3'b000, index_i[2:0]});
        desc_o[1] = tab(TAB_MASS, {1'b0, index_i[7:3]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_ADJ, index_i[13:8]);
        desc_o[4] = tab(TAB_NPL, {1'b0, index_i[18:14]});
        desc_o[5] = lit(8'd1);
        desc_o[6] = tab(TAB_INGINF, {1'b0, index_i[23:19]});
      end
      FR_G: begin
        desc_o[0] = tab(TAB_TIME, {2'b00, index_i[3:0]});
        desc_o[1] = tab(TAB_AMB, {2'b00, index_i[7:4]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_ADJ, index_i[13:8]);
        desc_o[4] = tab(TAB_MASS, {1'b0, index_i[18:14]});
        desc_o[5] = lit(8'd1);
        desc_o[6] = tab(TAB_ING, {1'b0, index_i[23:19]});
      end
      FR_H: begin
        desc_o[0] = tab(TAB_TIME, {2'b00, index_i[3:0]});
        desc_o[1] = tab(TAB_AMB, {2'b00, index_i[7:4]});
        desc_o[2] = lit(8'd1);
        desc_o[3] = tab(TAB_PREP, {3'b000, index_i[10:8]});
        desc_o[4] = lit(8'd5);
        desc_o[5] = tab(TAB_ADJ, index_i[16:11]);
        desc_o[6] = tab(TAB_NS, index_i[22:17]);
        desc_o[7] = lit(8'd3);
        desc_o[8] = lit(8'd1);
        desc_o[9] = tab(TAB_INGADJ, index_i[28:23]);
      end
      default: begin
        for (int i = 0; i < NUM_BYTES; i++) begin
          desc_o[i] = lit(8'd0);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/pow_seed_index_decoder_top.sv]
// pow_seed_index_decoder_top: three-stage pipeline from work index to the
// first ten seed bytes; depends on psid_pkg and psid_byte_map
//
//   channel  dir  tdata                    tuser
//   s_axis   in   [31:0] thread_index      -
//   m_axis   out  [79:0] seed_byte0..9     [0] in_range
//
// one item per cycle while the output is not stalled; each item is registered in
// stage 1 range compare, stage 2 byte layout, stage 3 table read
// each stage holds its item while the next one is full and stalled
// reset empties all stages; no state survives an item
`default_nettype none

module pow_seed_index_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] thread_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] seed_byte0 .. [79:72] seed_byte9
  output logic        m_axis_tuser    // [0] in_range
);
  import psid_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic [31:0] idx1_q;
  frame_e      frame1_q, frame1_d;
  logic        inr1_q, inr2_q, inr3_q;
  desc_t       desc2_d [NUM_BYTES];
  desc_t       desc2_q [NUM_BYTES];
  logic [7:0]  byte3_q [NUM_BYTES];

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_comb begin
    if (s_axis_tdata == '0 || s_axis_tdata > LIM_TOP) frame1_d = FR_ZERO;
    else if (s_axis_tdata <= LIM_A) frame1_d = FR_A;
    else if (s_axis_tdata <= LIM_B) frame1_d = FR_B;
    else if (s_axis_tdata <= LIM_C) frame1_d = FR_C;
    else if (s_axis_tdata <= LIM_D) frame1_d = FR_D;
    else if (s_axis_tdata <= LIM_E) frame1_d = FR_E;
    else if (s_axis_tdata <= LIM_F) frame1_d = FR_F;
    else if (s_axis_tdata <= LIM_G) frame1_d = FR_G;
    else frame1_d = FR_H;
  end

  psid_byte_map u_byte_map (
    .frame_i (frame1_q),
    .index_i (idx1_q),
    .desc_o  (desc2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      idx1_q   <= s_axis_tdata;
      frame1_q <= frame1_d;
      inr1_q   <= (s_axis_tdata <= LIM_TOP);
    end
    if (rdy2) begin
      desc2_q <= desc2_d;
      inr2_q  <= inr1_q;
    end
    if (rdy3) begin
      for (int i = 0; i < NUM_BYTES; i++) begin
        byte3_q[i] <= tab_read(desc2_q[i]);
      end
      inr3_q <= inr2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      m_axis_tdata[i*8 +: 8] = byte3_q[i];
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = inr3_q;

`ifndef SYNTHESIS
  // out of range items carry an all-zero seed
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out of range item with nonzero seed");

  // every frame but the zero frame sets a nonzero byte 2, so a zero byte 2 means the zero frame
  a_byte2_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23:16] == 8'd0 |-> m_axis_tdata == '0)
    else $error("partial seed with zero byte 2");

  // a stage 1 item handed on while stage 2 can move leaves stage 2 filled
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && rdy2 |=> v2_q)
    else $error("item lost between stage 1 and stage 2");

  // a stalled output keeps the stage behind it from overwriting it
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !m_axis_tready && v2_q |=> v2_q && v3_q)
    else $error("stall dropped a pipeline item");
`endif

endmodule

`default_nettype wire
